@@ src/ptfd_pkg.sv @@
// Shared types and constants for the port-tagged frame demultiplexer.
package ptfd_pkg;

  localparam int DATA_W     = 8;
  localparam int LEN_W      = 16;
  localparam int PORT_W     = 4;
  localparam int NPORT_W    = 5;
  localparam int MASK_W     = 16;
  localparam int ERR_W      = 2;
  localparam int HDR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Port numbers at or above this limit are always invalid
  localparam logic [NPORT_W-1:0] MAX_PORTS = 5'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_MASK  = 2'd1;

  // Header byte positions
  localparam logic [HDR_W-1:0] HDR_PORT_HI = 2'd0;
  localparam logic [HDR_W-1:0] HDR_PORT_LO = 2'd1;
  localparam logic [HDR_W-1:0] HDR_LEN_HI  = 2'd2;
  localparam logic [HDR_W-1:0] HDR_LEN_LO  = 2'd3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_OPEN,
    PH_CLOSED,
    PH_DISCARD
  } phase_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_SHORT_HDR,
    ERR_BAD_PORT,
    ERR_BAD_LEN
  } err_t;

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] port_id;
    logic [DATA_W-1:0] payload;
    logic              last_of_message;
    err_t              error_code;
  } result_t;

  // Write side of the result queue
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

@@ src/ptfd_if.sv @@
// Channel interfaces: input bytes, result items and configuration writes.
interface ptfd_byte_if import ptfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [LEN_W-1:0]  bytes_left;

  modport source (output valid, output data_byte, output bytes_left, input ready);
  modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface ptfd_result_if import ptfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PORT_W-1:0] port_id;
  logic [DATA_W-1:0] payload;
  logic              last_of_message;
  logic [ERR_W-1:0]  error_code;

  modport source (output valid, output kind, output port_id, output payload,
                  output last_of_message, output error_code, input ready);
  modport sink   (input valid, input kind, input port_id, input payload,
                  input last_of_message, input error_code, output ready);
endinterface

interface ptfd_cfg_if import ptfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ src/ptfd_front.sv @@
// Front end: header parser and per-byte classifier feeding the result queue.
module ptfd_front import ptfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  ptfd_byte_if.sink          bytes,
  input  logic [NPORT_W-1:0] port_count,
  input  logic [MASK_W-1:0]  port_open_mask,
  input  logic               space,
  output push_t              push
);

  phase_t             phase, phase_next;
  logic [HDR_W-1:0]   header_index, header_index_next;
  logic [LEN_W-1:0]   length_left, length_left_next;
  logic [DATA_W-1:0]  port_hi, port_hi_next;
  logic [PORT_W-1:0]  port_id, port_id_next;

  logic               in_acc;
  logic               last;
  logic [2:0]         need;
  logic [NPORT_W-1:0] lim;
  logic               port_bad;
  logic [LEN_W-1:0]   len_full;
  logic               len_bad;
  logic [LEN_W-1:0]   len_dec;
  err_t               err;

  assign bytes.ready = space;
  assign in_acc      = bytes.valid && space;
  assign last        = bytes.bytes_left <= LEN_W'(1);

  // Header checks
  assign need     = 3'd4 - {1'b0, header_index};
  assign lim      = (port_count > MAX_PORTS) ? MAX_PORTS : port_count;
  assign port_bad = (port_hi != '0) || (bytes.data_byte >= {3'b000, lim});
  assign len_full = {length_left[DATA_W-1:0], bytes.data_byte};
  assign len_bad  = (len_full == '0) || (len_full >= bytes.bytes_left);
  assign len_dec  = (length_left == '0) ? '0 : length_left - LEN_W'(1);

  // Outputs: error classification and the result pushed to the queue
  always_comb begin
    err = ERR_NONE;
    if (phase == PH_HEADER) begin
      if (bytes.bytes_left < {13'd0, need}) begin
        err = ERR_SHORT_HDR;
      end else if (header_index == HDR_PORT_LO && port_bad) begin
        err = ERR_BAD_PORT;
      end else if (header_index == HDR_LEN_LO && len_bad) begin
        err = ERR_BAD_LEN;
      end
    end

    push.valid = in_acc && ((err != ERR_NONE) || (phase == PH_OPEN));
    if (err != ERR_NONE) begin
      push.res.kind            = KIND_ERROR;
      push.res.port_id         = '0;
      push.res.payload         = '0;
      push.res.last_of_message = 1'b0;
    end else begin
      push.res.kind            = KIND_PAYLOAD;
      push.res.port_id         = port_id;
      push.res.payload         = bytes.data_byte;
      push.res.last_of_message = length_left <= LEN_W'(1);
    end
    push.res.error_code = err;
  end

  // Next state
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    length_left_next  = length_left;
    port_hi_next      = port_hi;
    port_id_next      = port_id;
    if (in_acc) begin
      unique case (phase)
        PH_HEADER: begin
          if (err != ERR_NONE) begin
            phase_next        = last ? PH_HEADER : PH_DISCARD;
            header_index_next = HDR_PORT_HI;
            length_left_next  = '0;
          end else begin
            unique case (header_index)
              HDR_PORT_HI: begin
                port_hi_next      = bytes.data_byte;
                header_index_next = HDR_PORT_LO;
              end
              HDR_PORT_LO: begin
                port_id_next      = bytes.data_byte[PORT_W-1:0];
                header_index_next = HDR_LEN_HI;
              end
              HDR_LEN_HI: begin
                length_left_next  = {{(LEN_W-DATA_W){1'b0}}, bytes.data_byte};
                header_index_next = HDR_LEN_LO;
              end
              HDR_LEN_LO: begin
                length_left_next  = len_full;
                phase_next        = port_open_mask[port_id] ? PH_OPEN : PH_CLOSED;
                header_index_next = HDR_PORT_HI;
              end
            endcase
          end
        end
        PH_OPEN, PH_CLOSED: begin
          if (len_dec == '0 || last) begin
            phase_next        = PH_HEADER;
            header_index_next = HDR_PORT_HI;
            length_left_next  = '0;
          end else begin
            length_left_next  = len_dec;
          end
        end
        PH_DISCARD: begin
          if (last) begin
            phase_next        = PH_HEADER;
            header_index_next = HDR_PORT_HI;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= HDR_PORT_HI;
      length_left  <= '0;
    end else begin
      phase        <= phase_next;
      header_index <= header_index_next;
      length_left  <= length_left_next;
    end
  end

  // Header fields
  always_ff @(posedge clk) begin
    port_hi <= port_hi_next;
    port_id <= port_id_next;
  end

`ifndef SYNTHESIS
  a_hdr_idx_only_in_header: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEADER |-> header_index == HDR_PORT_HI)
    else $error("header index left nonzero outside header phase");

  a_payload_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_OPEN || phase == PH_CLOSED) |-> length_left != '0)
    else $error("payload phase with no bytes due");

  a_error_discards: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.res.kind == KIND_ERROR && !last) |=> phase == PH_DISCARD)
    else $error("error not followed by discard");
`endif

endmodule

@@ src/ptfd_queue.sv @@
// Result queue between the front end and the output channel.
module ptfd_queue import ptfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  push_t          push,
  output logic           space,
  ptfd_result_if.source  result
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  result_t          head;

  assign pop   = result.valid && result.ready;
  assign space = count != CNT_W'(DEPTH);

  // Storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.res;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push.valid && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push.valid) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Head of queue drives the output channel
  assign head                   = mem[rd_ptr];
  assign result.valid           = count != '0;
  assign result.kind            = head.kind;
  assign result.port_id         = head.port_id;
  assign result.payload         = head.payload;
  assign result.last_of_message = head.last_of_message;
  assign result.error_code      = head.error_code;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !space |-> !push.valid)
    else $error("push into full queue");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push.valid && count == '0) |=> result.valid)
    else $error("pushed result not visible");
`endif

endmodule

@@ src/port_tagged_frame_demux.sv @@
// Top level of the port-tagged frame demultiplexer.
//
// Takes one byte of a received transfer per request, with the count of bytes
// left in the transfer, and parses 4-byte headers (port, length, both
// big-endian) followed by payload. Payload bytes for open ports come out
// tagged with their port and an end-of-message mark; closed-port bytes are
// dropped. A short header, invalid port or bad length yields one error report
// and the rest of the transfer is skipped. A byte is accepted in any cycle in
// which the QUEUE_DEPTH-entry result queue is not full: the header parser
// updates its state and any result goes into the queue. With the default
// depth of 2 bytes flow at one per cycle while the sink takes a result every
// cycle; once a sink stall fills the queue, input is held off while the queue
// is full, even if a result leaves in that cycle. At depth 1 no byte is
// accepted while a result is still queued. A result is written into the queue
// when its byte is accepted and comes out after any older results still queued.
// Configuration writes are taken every cycle and must only be issued while
// the block is idle.
module port_tagged_frame_demux import ptfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  ptfd_byte_if.sink     bytes,
  ptfd_result_if.source result,
  ptfd_cfg_if.sink      cfg
);

  logic [NPORT_W-1:0] port_count;
  logic [MASK_W-1:0]  port_open_mask;
  logic               space;
  push_t              push;

  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_count     <= MAX_PORTS;
      port_open_mask <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PORT_COUNT: port_count     <= cfg.wdata[NPORT_W-1:0];
        CFG_PORT_MASK:  port_open_mask <= cfg.wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  ptfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .bytes          (bytes),
    .port_count     (port_count),
    .port_open_mask (port_open_mask),
    .space          (space),
    .push           (push)
  );

  ptfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .space  (space),
    .result (result)
  );

endmodule

@@ dv/tb_port_tagged_frame_demux.sv @@
// Self-checking testbench for the port-tagged frame demultiplexer.
module tb_port_tagged_frame_demux;
  timeunit 1ns;
  timeprecision 1ps;
  import ptfd_pkg::*;

  // Deframer predictor with the queue of results it still owes
  class frame_sb;
    phase_t             ph;
    logic [HDR_W-1:0]   hdr_pos;
    logic [15:0]        port_word;
    logic [15:0]        len_left;
    logic [NPORT_W-1:0] port_count;
    logic [MASK_W-1:0]  open_mask;
    result_t            due_q[$];
    int                 errors;

    function new();
      ph         = PH_HEADER;
      hdr_pos    = HDR_PORT_HI;
      port_word  = '0;
      len_left   = '0;
      port_count = MAX_PORTS;
      open_mask  = '0;
      errors     = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PORT_COUNT) port_count = val[NPORT_W-1:0];
      else if (idx == CFG_PORT_MASK) open_mask = val;
    endfunction

    // Advance the parser by one accepted request; queue what it produces
    function void note_request(logic [DATA_W-1:0] b, logic [LEN_W-1:0] bl);
      logic               last_byte;
      logic [2:0]         need;
      logic [NPORT_W-1:0] lim;
      err_t               code;
      result_t            r;
      last_byte = (bl <= 1);
      code      = ERR_NONE;
      r         = '0;
      case (ph)
        PH_HEADER: begin
          need = 3'd4 - {1'b0, hdr_pos};
          if (bl < need) begin
            code = ERR_SHORT_HDR;
          end else begin
            case (hdr_pos)
              HDR_PORT_HI: begin
                port_word = {8'h00, b};
                hdr_pos   = HDR_PORT_LO;
              end
              HDR_PORT_LO: begin
                lim       = (port_count > MAX_PORTS) ? MAX_PORTS : port_count;
                port_word = {port_word[7:0], b};
                if (port_word >= lim) code = ERR_BAD_PORT;
                else hdr_pos = HDR_LEN_HI;
              end
              HDR_LEN_HI: begin
                len_left = {8'h00, b};
                hdr_pos  = HDR_LEN_LO;
              end
              default: begin
                len_left = {len_left[7:0], b};
                // 17-bit compare: bl of zero wraps, as the unsigned math does
                if (len_left == 0 || {1'b0, len_left} > {1'b0, bl} - 17'd1) begin
                  code = ERR_BAD_LEN;
                end else begin
                  ph      = open_mask[port_word[PORT_W-1:0]] ? PH_OPEN : PH_CLOSED;
                  hdr_pos = HDR_PORT_HI;
                end
              end
            endcase
          end
          if (code != ERR_NONE) begin
            r.kind       = KIND_ERROR;
            r.error_code = code;
            due_q.push_back(r);
            ph       = last_byte ? PH_HEADER : PH_DISCARD;
            hdr_pos  = HDR_PORT_HI;
            len_left = '0;
          end
        end
        PH_OPEN, PH_CLOSED: begin
          if (ph == PH_OPEN) begin
            r.kind            = KIND_PAYLOAD;
            r.port_id         = port_word[PORT_W-1:0];
            r.payload         = b;
            r.last_of_message = (len_left <= 1);
            r.error_code      = ERR_NONE;
            due_q.push_back(r);
          end
          if (len_left != 0) len_left = len_left - 1'b1;
          if (len_left == 0 || last_byte) begin
            ph       = PH_HEADER;
            hdr_pos  = HDR_PORT_HI;
            len_left = '0;
          end
        end
        default: begin
          if (last_byte) begin
            ph      = PH_HEADER;
            hdr_pos = HDR_PORT_HI;
          end
        end
      endcase
    endfunction

    // Compare one delivered result with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result kind %0b port %0h byte %02h code %0d",
                         got.kind, got.port_id, got.payload, got.error_code));
        return;
      end
      want = due_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind got %0b exp %0b", got.kind, want.kind));
      if (got.port_id !== want.port_id)
        report($sformatf("port_id got %0h exp %0h", got.port_id, want.port_id));
      if (got.payload !== want.payload)
        report($sformatf("payload got %02h exp %02h", got.payload, want.payload));
      if (got.last_of_message !== want.last_of_message)
        report($sformatf("last_of_message got %0b exp %0b",
                         got.last_of_message, want.last_of_message));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code got %0d exp %0d", got.error_code, want.error_code));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ptfd_byte_if   bytes_ch ();
  ptfd_result_if res_ch ();
  ptfd_cfg_if    cfg_ch ();

  port_tagged_frame_demux u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  frame_sb sb;
  result_t seen;
  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  int      sent_count    = 0;
  int      cfg_nports    = 16;

  always #4 clk = ~clk;

  // Sink side: random stalls on result ready
  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // Observe every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.wdata);
      if (bytes_ch.valid && bytes_ch.ready)
        sb.note_request(bytes_ch.data_byte, bytes_ch.bytes_left);
      if (res_ch.valid && res_ch.ready) begin
        seen.kind            = res_ch.kind;
        seen.port_id         = res_ch.port_id;
        seen.payload         = res_ch.payload;
        seen.last_of_message = res_ch.last_of_message;
        seen.error_code      = err_t'(res_ch.error_code);
        sb.check_result(seen);
      end
    end
  end

  function void set_idling(int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 68; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 68; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic push_byte(input logic [DATA_W-1:0] b, input logic [LEN_W-1:0] bl);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_ch.valid = 1'b0;
      @(negedge clk);
    end
    bytes_ch.valid      = 1'b1;
    bytes_ch.data_byte  = b;
    bytes_ch.bytes_left = bl;
    do @(posedge clk); while (!bytes_ch.ready);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.wdata = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == CFG_PORT_COUNT) cfg_nports = val[NPORT_W-1:0];
  endtask

  // Hold off the sender until every owed result is back
  task automatic wait_drained();
    bytes_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Send one transfer; bytes_left counts down from the declared size, the last byte gets last_bl
  task automatic send_transfer(input logic [7:0] xq[$], input int declared,
                               input logic [LEN_W-1:0] last_bl);
    int n;
    logic [LEN_W-1:0] bl;
    n = xq.size();
    for (int i = 0; i < n; i++) begin
      bl = (i == n - 1) ? last_bl : LEN_W'(declared - i);
      if ($urandom_range(299) == 0) wait_drained();
      push_byte(xq[i], bl);
    end
  endtask

  // Mostly well-formed messages, with broken headers and noise mixed in
  task automatic random_transfer();
    logic [7:0]  xq[$];
    logic [15:0] pnum;
    logic [15:0] len16;
    int n_msg, pick, eff, declared, len, cnt, cut;
    eff   = (cfg_nports > 16) ? 16 : cfg_nports;
    n_msg = $urandom_range(4, 1);
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(12, 1)) xq.push_back(8'($urandom_range(255)));
    end else begin
      for (int m = 0; m < n_msg; m++) begin
        pick = $urandom_range(99);
        pnum = (eff > 0) ? 16'($urandom_range(eff - 1)) : 16'($urandom_range(65535));
        len  = $urandom_range(6, 1);
        cnt  = len;
        if (pick < 8) begin
          pnum = 16'($urandom_range(65535, eff));
        end else if (pick < 14) begin
          len = 0;
          cnt = $urandom_range(3);
        end else if (pick < 20) begin
          len = $urandom_range(65535, 7);
          cnt = $urandom_range(6);
        end else if (pick < 26) begin
          len = $urandom_range(40, 7);
          cnt = len;
        end else if (pick < 32) begin
          cnt = $urandom_range(len - 1);
        end
        cut   = (pick >= 95) ? $urandom_range(3) : 4;
        len16 = 16'(len);
        if (cut > 0) xq.push_back(pnum[15:8]);
        if (cut > 1) xq.push_back(pnum[7:0]);
        if (cut > 2) xq.push_back(len16[15:8]);
        if (cut < 4) break;
        xq.push_back(len16[7:0]);
        repeat (cnt) xq.push_back(8'($urandom_range(255)));
      end
    end
    if (xq.size() == 0) xq.push_back(8'($urandom_range(255)));
    declared = xq.size();
    if ($urandom_range(6) == 0) declared = $urandom_range(65535, xq.size());
    send_transfer(xq, declared, ($urandom_range(39) == 0) ? 16'd0 : 16'd1);
  endtask

  initial begin
    int          nports_tbl[8];
    logic [15:0] mask_tbl[8];
    logic [15:0] mask_val;
    int          stop_at;
    nports_tbl = '{16, 1, 0, 31, 4, 17, 9, 2};
    mask_tbl   = '{16'hFFFF, 16'h0000, 16'hA5C3, 16'hFFFF, 16'h0005, 16'h8001,
                   16'h0000, 16'h0003};
    sb                  = new();
    rst                 = 1'b1;
    bytes_ch.valid      = 1'b0;
    bytes_ch.data_byte  = '0;
    bytes_ch.bytes_left = 16'd1;
    res_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_PORT_COUNT;
    cfg_ch.wdata        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: four ports, ports 0 and 2 open
    set_idling(0);
    cfg_write(CFG_PORT_COUNT, 16'd4);
    cfg_write(CFG_PORT_MASK, 16'h0005);
    // open port, two payload bytes at the data extremes
    send_transfer('{8'h00, 8'h02, 8'h00, 8'h02, 8'hFF, 8'h00}, 6, 16'd1);
    // closed port dropped, then a header cut short by the transfer end
    send_transfer('{8'h00, 8'h01, 8'h00, 8'h01, 8'hAB, 8'h00, 8'h03}, 7, 16'd1);
    // port number above the limit, rest discarded
    send_transfer('{8'hFF, 8'h03, 8'h7E}, 6, 16'd1);
    // zero length on the last byte: error, no discard
    send_transfer('{8'h00, 8'h00, 8'h00, 8'h00}, 4, 16'd1);
    // overlong length, transfer closed by a zero bytes_left
    send_transfer('{8'h00, 8'h00, 8'h00, 8'h09, 8'h12}, 5, 16'd0);

    // Random phases, each with its own register settings and idling mode
    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      wait_drained();
      mask_val = (ph_i % 3 == 2) ? 16'($urandom_range(65535)) : mask_tbl[ph_i];
      cfg_write(CFG_PORT_COUNT, 16'(nports_tbl[ph_i]));
      cfg_write(CFG_PORT_MASK, mask_val);
      set_idling(ph_i % 4);
      stop_at = sent_count + 112;
      while (sent_count < stop_at) random_transfer();
    end

    bytes_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/ptfd_pkg.sv
src/ptfd_if.sv
src/ptfd_front.sv
src/ptfd_queue.sv
src/port_tagged_frame_demux.sv
dv/tb_port_tagged_frame_demux.sv
